// ----- hw/rtl/srl_pkg.sv -----
// Package for the S-record line checker: item types, constants and the hex decoder.
`default_nettype none

package srl_pkg;

  localparam int unsigned IdxW   = 10;
  localparam logic [IdxW-1:0] IdxMax = '1;

  localparam logic [7:0] CharS     = 8'h53;  // 'S'
  localparam logic [7:0] TypeOne   = 8'h31;  // '1'
  localparam logic [7:0] TypeNine  = 8'h39;  // '9'
  localparam logic [7:0] SumTarget = 8'hFF;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } item_t;

  typedef struct packed {
    logic       header_ok;
    logic [7:0] record_type;
    logic [7:0] byte_count;
    logic [7:0] byte_sum;
    logic       sum_checked;
    logic       sum_ok;
    logic       bad_digit;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  // Decodes one ASCII hex digit; anything else gives zero and no valid flag.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/srl_in_if.sv -----
// Character channel of the S-record line checker.
`default_nettype none

interface srl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink   (input valid, input ch, input line_end, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/srl_out_if.sv -----
// Report channel of the S-record line checker.
`default_nettype none

interface srl_out_if;
  logic       valid;
  logic       ready;
  logic       header_ok;
  logic [7:0] record_type;
  logic [7:0] byte_count;
  logic [7:0] byte_sum;
  logic       sum_checked;
  logic       sum_ok;
  logic       bad_digit;

  modport source (output valid, output header_ok, output record_type, output byte_count,
                  output byte_sum, output sum_checked, output sum_ok, output bad_digit,
                  input ready);
  modport sink   (input valid, input header_ok, input record_type, input byte_count,
                  input byte_sum, input sum_checked, input sum_ok, input bad_digit,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/srl_core.sv -----
// Running line state of the S-record checker and the report for the line end.
`default_nettype none

module srl_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  srl_pkg::item_t  item,
  output srl_pkg::result_t result
);

  logic [srl_pkg::IdxW-1:0] char_index, char_index_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic [7:0] count_value, count_value_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] type_char, type_char_next;
  logic       start_ok, start_ok_next;
  logic       digit_error, digit_error_next;

  logic [srl_pkg::IdxW-1:0] pos;
  logic [srl_pkg::IdxW-2:0] byte_no;
  logic [7:0]               byte_val;
  srl_pkg::hex_t            hex;

  assign pos      = char_index - srl_pkg::IdxW'(2);
  assign byte_no  = pos[srl_pkg::IdxW-1:1];
  assign hex      = srl_pkg::hex_decode(item.ch);
  assign byte_val = {high_nibble, hex.value};

  always_comb begin
    char_index_next  = char_index;
    high_nibble_next = high_nibble;
    count_value_next = count_value;
    running_sum_next = running_sum;
    type_char_next   = type_char;
    start_ok_next    = start_ok;
    digit_error_next = digit_error;

    if (char_index == '0) begin
      start_ok_next = (item.ch == srl_pkg::CharS);
    end else if (char_index == srl_pkg::IdxW'(1)) begin
      type_char_next = item.ch;
    end else if (byte_no <= {1'b0, count_value}) begin
      // Characters past the counted bytes fall outside this branch and are ignored.
      if (!hex.valid) begin
        digit_error_next = 1'b1;
      end
      if (!pos[0]) begin
        high_nibble_next = hex.value;
      end else begin
        running_sum_next = running_sum + byte_val;
        if (byte_no == '0) begin
          count_value_next = byte_val;
        end
      end
    end

    if (char_index != srl_pkg::IdxMax) begin
      char_index_next = char_index + srl_pkg::IdxW'(1);
    end
  end

  always_comb begin
    result.header_ok   = start_ok_next;
    result.record_type = type_char_next;
    result.byte_count  = count_value_next;
    result.byte_sum    = running_sum_next;
    result.sum_checked = start_ok_next &&
                         (type_char_next == srl_pkg::TypeOne ||
                          type_char_next == srl_pkg::TypeNine);
    result.sum_ok      = !result.sum_checked || (running_sum_next == srl_pkg::SumTarget);
    result.bad_digit   = digit_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.line_end)) begin
      char_index  <= '0;
      high_nibble <= '0;
      count_value <= '0;
      running_sum <= '0;
      type_char   <= '0;
      start_ok    <= 1'b0;
      digit_error <= 1'b0;
    end else if (take) begin
      char_index  <= char_index_next;
      high_nibble <= high_nibble_next;
      count_value <= count_value_next;
      running_sum <= running_sum_next;
      type_char   <= type_char_next;
      start_ok    <= start_ok_next;
      digit_error <= digit_error_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/srecord_line_checker.sv -----
// Top level of the S-record line checker: input register, line state and report register.
//
//   Channel  Modport  Request                   Moves
//   chars    sink     one line character        ch, line_end
//   reports  source   one report per line end   header_ok .. bad_digit
//
// A character is taken in every cycle unless a line end waits on a stalled report. A line
// end's report is loaded at the edge where the character leaves the input register, and
// the report register then offers it on the reports channel.
// The only loop is the running line state in srl_core, updated once per character.
// Reset clears the valid flags and the line state; no payload register is cleared.
// A stalled report holds only line-end characters back; others keep flowing.
`default_nettype none

module srecord_line_checker (
  input  logic      clk,
  input  logic      rst,
  srl_in_if.sink    chars,
  srl_out_if.source reports
);

  srl_pkg::item_t   item;
  logic             item_valid;
  srl_pkg::result_t core_result;
  srl_pkg::result_t report;
  logic             report_valid;
  logic             adv;

  assign adv         = item_valid && (!item.line_end || !report_valid || reports.ready);
  assign chars.ready = !item_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (chars.ready) begin
      item_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      item.ch       <= chars.ch;
      item.line_end <= chars.line_end;
    end
  end

  srl_core u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (adv),
    .item   (item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (adv && item.line_end) begin
      report_valid <= 1'b1;
    end else if (reports.ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item.line_end) begin
      report <= core_result;
    end
  end

  assign reports.valid       = report_valid;
  assign reports.header_ok   = report.header_ok;
  assign reports.record_type = report.record_type;
  assign reports.byte_count  = report.byte_count;
  assign reports.byte_sum    = report.byte_sum;
  assign reports.sum_checked = report.sum_checked;
  assign reports.sum_ok      = report.sum_ok;
  assign reports.bad_digit   = report.bad_digit;

  // A character that is not a line end never waits on the report side.
  a_mid_char_flows: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item.line_end) |-> adv)
    else $error("mid-line character held in input register");

  a_report_source: assert property (@(posedge clk) disable iff (rst)
    $rose(report_valid) |-> $past(adv && item.line_end))
    else $error("report raised without a line end");

  a_failed_implies_checked: assert property (@(posedge clk) disable iff (rst)
    (report_valid && !report.sum_ok) |-> report.sum_checked)
    else $error("sum failure on an unchecked record");

  a_checked_needs_header: assert property (@(posedge clk) disable iff (rst)
    (report_valid && report.sum_checked) |-> report.header_ok)
    else $error("sum checked without an S header");

endmodule

`default_nettype wire

// ----- dv/srecord_line_checker_test.sv -----
// Self-checking testbench for the S-record line checker: random and directed lines.
`timescale 1ns / 100ps

module srecord_line_checker_test;

  typedef enum int {FlawNone, FlawSum, FlawDigit, FlawShort} flaw_e;

  typedef struct packed {
    logic           hold;
    srl_pkg::item_t it;
  } char_req_t;

  logic clk;
  logic rst;

  srl_in_if  chars_if ();
  srl_out_if reports_if ();

  srecord_line_checker u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .reports (reports_if)
  );

  char_req_t        pending_chars[$];
  srl_pkg::result_t expected_reports[$];
  logic [7:0]       line_buf[$];
  logic             hold_next;
  int               taken_chars = 0;
  int               mismatches = 0;
  logic             calm;

  // Running state of the line being predicted.
  logic [srl_pkg::IdxW-1:0] line_pos = '0;
  logic [3:0]               nib_hi = '0;
  logic [7:0]               cnt_byte = '0;
  logic [7:0]               sum_byte = '0;
  logic [7:0]               type_byte = '0;
  logic                     s_seen = 1'b0;
  logic                     digit_bad = 1'b0;

  // Neither side idles at random while this stretch of requests goes through.
  assign calm = (taken_chars >= 300) && (taken_chars < 500);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Bit 4 flags a hex digit, bits 3:0 hold its value (zero for anything else).
  function automatic logic [4:0] decode_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    if ($urandom_range(1) == 0) return "A" + v - 8'd10;
    return "a" + v - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (decode_digit(c) != 5'd0) c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic clear_line();
    line_pos  = '0;
    nib_hi    = '0;
    cnt_byte  = '0;
    sum_byte  = '0;
    type_byte = '0;
    s_seen    = 1'b0;
    digit_bad = 1'b0;
  endtask

  task automatic predict_char(input logic [7:0] c, input logic last);
    logic [4:0]       d;
    int               pos;
    srl_pkg::result_t r;
    if (line_pos == 0) begin
      s_seen = (c == srl_pkg::CharS);
    end else if (line_pos == 1) begin
      type_byte = c;
    end else begin
      pos = line_pos - 2;
      // Only the count byte and the bytes that it covers are summed.
      if ((pos / 2) <= cnt_byte) begin
        d = decode_digit(c);
        if (!d[4]) digit_bad = 1'b1;
        if (pos % 2 == 0) begin
          nib_hi = d[3:0];
        end else begin
          sum_byte = sum_byte + {nib_hi, d[3:0]};
          if (pos / 2 == 0) cnt_byte = {nib_hi, d[3:0]};
        end
      end
    end
    if (line_pos != srl_pkg::IdxMax) line_pos = line_pos + 1'b1;
    if (last) begin
      r.header_ok   = s_seen;
      r.record_type = type_byte;
      r.byte_count  = cnt_byte;
      r.byte_sum    = sum_byte;
      r.sum_checked = s_seen && (type_byte == srl_pkg::TypeOne ||
                                 type_byte == srl_pkg::TypeNine);
      r.sum_ok      = !r.sum_checked || (sum_byte == srl_pkg::SumTarget);
      r.bad_digit   = digit_bad;
      expected_reports.push_back(r);
      clear_line();
    end
  endtask

  task automatic note_error(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) note_error(what, want, got);
  endtask

  // Moves the assembled line into the request queue, flagging its last character.
  task automatic emit_line();
    char_req_t r;
    for (int i = 0; i < line_buf.size(); i++) begin
      r.hold        = hold_next && (i == 0);
      r.it.ch       = line_buf[i];
      r.it.line_end = (i == line_buf.size() - 1);
      pending_chars.push_back(r);
    end
    hold_next = 1'b0;
    line_buf.delete();
  endtask

  task automatic text_line(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    emit_line();
  endtask

  task automatic put_byte(input logic [7:0] b);
    line_buf.push_back(digit_char(b[7:4]));
    line_buf.push_back(digit_char(b[3:0]));
  endtask

  task automatic make_record(input flaw_e flaw);
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    int         cut;
    line_buf.push_back(srl_pkg::CharS);
    case ($urandom_range(3))
      0: line_buf.push_back(srl_pkg::TypeOne);
      1: line_buf.push_back(srl_pkg::TypeNine);
      default: line_buf.push_back(8'h30 + 8'($urandom_range(9)));
    endcase
    n = $urandom_range(12);
    sum = 8'(n + 1);
    put_byte(sum);
    repeat (n) begin
      b = 8'($urandom_range(255));
      sum = sum + b;
      put_byte(b);
    end
    b = ~sum;
    if (flaw == FlawSum) b = b ^ 8'($urandom_range(255, 1));
    put_byte(b);
    if (flaw == FlawDigit) line_buf[$urandom_range(line_buf.size() - 1, 2)] = non_hex_char();
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(6, 1)) line_buf.push_back(8'($urandom_range(255)));
    end
    if (flaw == FlawShort) begin
      cut = $urandom_range(line_buf.size() - 1, 1);
      while (line_buf.size() > cut) line_buf.delete(line_buf.size() - 1);
    end
    emit_line();
  endtask

  // Random count byte with only a few digits after it, so most of these end early.
  task automatic make_open_count();
    line_buf.push_back(srl_pkg::CharS);
    line_buf.push_back(8'($urandom_range(255)));
    put_byte(8'($urandom_range(255)));
    repeat ($urandom_range(16)) line_buf.push_back(digit_char(4'($urandom_range(15))));
    emit_line();
  endtask

  task automatic make_noise();
    if ($urandom_range(1) == 0) line_buf.push_back(srl_pkg::CharS);
    repeat ($urandom_range(20, 1)) line_buf.push_back(8'($urandom_range(255)));
    emit_line();
  endtask

  // Runs past every position that a count byte could cover, so its tail is never summed.
  task automatic make_long_line();
    line_buf.push_back(srl_pkg::CharS);
    line_buf.push_back(srl_pkg::TypeOne);
    put_byte(8'h00);
    put_byte(8'hFF);
    repeat (600) line_buf.push_back(8'($urandom_range(255)));
    emit_line();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else begin
      if (chars_if.valid && chars_if.ready) begin
        predict_char(chars_if.ch, chars_if.line_end);
        taken_chars++;
      end
      if (!chars_if.valid || chars_if.ready) begin
        if (pending_chars.size() != 0 && (calm || $urandom_range(99) >= 33) &&
            !(pending_chars[0].hold && expected_reports.size() != 0)) begin
          chars_if.valid    <= 1'b1;
          chars_if.ch       <= pending_chars[0].it.ch;
          chars_if.line_end <= pending_chars[0].it.line_end;
          pending_chars.pop_front();
        end else begin
          chars_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    srl_pkg::result_t want;
    if (rst) begin
      reports_if.ready <= 1'b0;
    end else begin
      if (reports_if.valid && reports_if.ready) begin
        if (expected_reports.size() == 0) begin
          note_error("unexpected report, record_type", 0, reports_if.record_type);
        end else begin
          want = expected_reports.pop_front();
          check_field("header_ok", want.header_ok, reports_if.header_ok);
          check_field("record_type", want.record_type, reports_if.record_type);
          check_field("byte_count", want.byte_count, reports_if.byte_count);
          check_field("byte_sum", want.byte_sum, reports_if.byte_sum);
          check_field("sum_checked", want.sum_checked, reports_if.sum_checked);
          check_field("sum_ok", want.sum_ok, reports_if.sum_ok);
          check_field("bad_digit", want.bad_digit, reports_if.bad_digit);
        end
      end
      reports_if.ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  initial begin
    int  pick;
    bit  long_done;
    bit  mid_hold_done;
    rst                 = 1'b1;
    hold_next           = 1'b0;
    long_done           = 1'b0;
    mid_hold_done       = 1'b0;

    // Directed lines: valid S9, lower case digits with bytes past the count,
    // a non-hex digit, the character extremes and a line cut after the type.
    text_line("S9030000FC");
    text_line("S101feZz");
    text_line("S50G");
    line_buf.push_back(8'hFF);
    emit_line();
    line_buf.push_back(srl_pkg::CharS);
    line_buf.push_back(8'h00);
    emit_line();
    text_line("S1");

    hold_next = 1'b1;
    while (pending_chars.size() < 900) begin
      if (!mid_hold_done && pending_chars.size() > 450) begin
        hold_next     = 1'b1;
        mid_hold_done = 1'b1;
      end
      if (!long_done && pending_chars.size() > 150) begin
        make_long_line();
        long_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 55)      make_record(FlawNone);
      else if (pick < 65) make_record(FlawSum);
      else if (pick < 75) make_record(FlawDigit);
      else if (pick < 82) make_record(FlawShort);
      else if (pick < 90) make_open_count();
      else                make_noise();
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || chars_if.valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/srl_pkg.sv
hw/rtl/srl_in_if.sv
hw/rtl/srl_out_if.sv
hw/rtl/srl_core.sv
hw/rtl/srecord_line_checker.sv
dv/srecord_line_checker_test.sv
